[rtl/core/u8dec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types, constants and the lead byte decode for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int OBUF_DEPTH = 4;
    localparam int BYTE_W     = 8;
    localparam int CP_W       = 16;

    localparam logic [7:0] LEAD_BAD_MIN = 8'hF0;
    localparam logic [7:0] LEAD3_MIN    = 8'hE0;
    localparam logic [7:0] LEAD2_MIN    = 8'hC0;
    localparam logic [7:0] CONT_MIN     = 8'h80;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_TAG     = 8'h80;

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            invalid;
        logic            last;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } step_t;

    typedef struct packed {
        logic            has_result;
        result_t         res;
        logic [1:0]      pend;
        logic [CP_W-1:0] pv;
    } lead_t;

    function automatic lead_t lead_decode(logic [BYTE_W-1:0] b);
        lead_t l;
        l.has_result     = 1'b1;
        l.res.code_point = '0;
        l.res.invalid    = 1'b1;
        l.res.last       = 1'b1;
        l.pend           = PEND_NONE;
        l.pv             = '0;
        if (b >= LEAD_BAD_MIN) begin
            l.has_result = 1'b1;
        end else if (b >= LEAD3_MIN) begin
            l.has_result = 1'b0;
            l.pend       = PEND_TWO;
            l.pv         = {b[3:0], 12'd0};
        end else if (b >= LEAD2_MIN) begin
            l.has_result = 1'b0;
            l.pend       = PEND_ONE;
            l.pv         = {5'd0, b[4:0], 6'd0};
        end else if (b >= CONT_MIN) begin
            l.has_result = 1'b1;
        end else begin
            l.res.code_point = {8'd0, b};
            l.res.invalid    = 1'b0;
        end
        return l;
    endfunction

endpackage

[rtl/core/u8dec_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_step
// Sequence state and per-byte decode; yields zero, one or two results.
// ----------------------------------------------------------------------------
module u8dec_step
    import u8dec_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [BYTE_W-1:0] byte_in,
    output step_t             step
);

    logic [1:0]      pending_reg, pending_next;
    logic [CP_W-1:0] pv_reg, pv_next;
    logic            is_cont;
    lead_t           lead;
    logic [CP_W-1:0] pv_sum;

    assign is_cont = ((byte_in & CONT_MASK) == CONT_TAG);
    assign lead    = lead_decode(byte_in);
    assign pv_sum  = (pending_reg >= PEND_TWO) ? pv_reg + {4'd0, byte_in[5:0], 6'd0}
                                               : pv_reg + {10'd0, byte_in[5:0]};

    always_comb begin
        step         = '0;
        pending_next = pending_reg;
        pv_next      = pv_reg;
        if (pending_reg == PEND_NONE) begin
            step.n       = {1'b0, lead.has_result};
            step.r0      = lead.res;
            pending_next = lead.pend;
            pv_next      = lead.has_result ? pv_reg : lead.pv;
        end else if (is_cont) begin
            if (pending_reg >= PEND_TWO) begin
                pending_next = PEND_ONE;
                pv_next      = pv_sum;
            end else begin
                step.n             = 2'd1;
                step.r0.code_point = pv_sum;
                step.r0.invalid    = 1'b0;
                step.r0.last       = 1'b1;
                pending_next       = PEND_NONE;
                pv_next            = '0;
            end
        end else begin
            step.n          = lead.has_result ? 2'd2 : 2'd1;
            step.r0.invalid = 1'b1;
            step.r0.last    = ~lead.has_result;
            step.r1         = lead.res;
            pending_next    = lead.pend;
            pv_next         = lead.has_result ? '0 : lead.pv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= PEND_NONE;
            pv_reg      <= '0;
        end else if (take) begin
            pending_reg <= pending_next;
            pv_reg      <= pv_next;
        end
    end

    a_pend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3) else $error("pending count out of range");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg == PEND_NONE) |-> (pv_reg == '0))
        else $error("partial value left over with nothing pending");

    a_broken_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg != PEND_NONE && !is_cont) |-> (step.n != 2'd0 && step.r0.invalid))
        else $error("broken sequence without error result");

endmodule

[rtl/core/u8dec_obuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_obuf
// Result buffer: takes up to two results per cycle, hands out one per request.
// ----------------------------------------------------------------------------
module u8dec_obuf
    import u8dec_pkg::*;
#(
    parameter int DEPTH = OBUF_DEPTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  step_t   step,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t             mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [1:0]          n_in;
    logic                pop;
    logic [PTR_W-1:0]    wr_ptr_p1;

    assign n_in      = push ? step.n : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_data  = mem[rd_ptr_reg];
    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_in);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(n_in) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (n_in != 2'd0) begin
            mem[wr_ptr_reg] <= step.r0;
        end
        if (n_in == 2'd2) begin
            mem[wr_ptr_p1] <= step.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH)) else $error("result buffer overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> room) else $error("push without room");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && n_in == 2'd0) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("count did not drop on request");

endmodule

[rtl/core/utf8_byte_stream_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// UTF-8 to 16-bit code point decoder, one byte per request.
//
// Input channel s_*: one raw byte per request in s_tdata.
// Result channel m_*: m_tdata carries the code point, m_tuser flags an
// invalid or unsupported sequence (code point 0), m_tlast marks the last
// result caused by one input byte. A byte that breaks a sequence gives an
// error result and is then decoded again as a lead byte, so one byte can
// give two results; lead bytes of two- and three-byte sequences and inner
// continuation bytes give none. A result enters the registered buffer when
// the byte that completes it is taken. Throughput: one byte per cycle while
// s_tready is high; the decode is a single level of masking and adding in
// front of a four-entry result buffer, which can take two results per cycle.
// s_tready drops while fewer than two buffer entries are free, so a
// stalled receiver holds the input back after at most a few bytes.
// Reset clears the sequence state and empties the buffer.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder
    import u8dec_pkg::*;
#(
    parameter int DEPTH = OBUF_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] byte_in
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CP_W-1:0]   m_tdata,   // [15:0] code_point
    output logic              m_tuser,   // [0] invalid
    output logic              m_tlast
);

    logic    take;
    step_t   step;
    result_t head;

    assign take = s_tvalid && s_tready;

    u8dec_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .byte_in (s_tdata),
        .step    (step)
    );

    u8dec_obuf #(
        .DEPTH (DEPTH)
    ) u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (take),
        .step      (step),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = head.code_point;
    assign m_tuser = head.invalid;
    assign m_tlast = head.last;

endmodule
